// ===== hdl/apwd_pkg.sv =====
`default_nettype none

package apwd_pkg;

	localparam int COUNT_BITS_DEF = 35;
	localparam int HDR_BYTES = 12;
	localparam int ADPCM_HDR_BYTES = 4;
	localparam int MAX_RES = 3;
	localparam logic [6:0] IDX_MAX = 7'd88;

	localparam logic [7:0] FMT_PCM8 = 8'd0;
	localparam logic [7:0] FMT_PCM16 = 8'd1;
	localparam logic [7:0] FMT_ADPCM = 8'd2;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_INFO = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_SHORT = 2'd0,
		ERR_FORMAT = 2'd1,
		ERR_ADPCM_HDR = 2'd2
	} err_t;

	typedef struct packed {
		kind_t kind;
		logic signed [15:0] sample;
		logic [15:0] play_rate;
		logic loop_enabled;
		logic [18:0] loop_point;
		err_t error_code;
		logic last;
	} result_t;

	typedef struct packed {
		logic load;
		logic [1:0] count;
	} res_load_t;

	typedef struct packed {
		logic signed [15:0] pred;
		logic [6:0] idx;
	} adpcm_st_t;

	localparam logic [14:0] STEP_TAB [89] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
		15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
		15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107,
		15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230,
		15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494,
		15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963, 15'd1060,
		15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066,
		15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026,
		15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845,
		15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289,
		15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
		15'd32767
	};

	localparam logic signed [7:0] IDX_ADJ [8] = '{
		-8'sd1, -8'sd1, -8'sd1, -8'sd1, 8'sd2, 8'sd4, 8'sd6, 8'sd8
	};

	function automatic adpcm_st_t nibble_step(adpcm_st_t cur, logic [3:0] nib);
		logic [6:0] si;
		logic [14:0] stp;
		logic [17:0] diff;
		logic signed [17:0] acc;
		logic signed [7:0] ix;
		adpcm_st_t r;
		si = (cur.idx > IDX_MAX) ? IDX_MAX : cur.idx;
		stp = STEP_TAB[si];
		diff = {3'b000, stp >> 3};
		if (nib[2]) begin
			diff = diff + {3'b000, stp};
		end
		if (nib[1]) begin
			diff = diff + {3'b000, stp >> 1};
		end
		if (nib[0]) begin
			diff = diff + {3'b000, stp >> 2};
		end
		if (nib[3]) begin
			acc = {{2{cur.pred[15]}}, cur.pred} - $signed(diff);
		end else begin
			acc = {{2{cur.pred[15]}}, cur.pred} + $signed(diff);
		end
		if (acc < -18'sd32768) begin
			r.pred = -16'sd32768;
		end else if (acc > 18'sd32767) begin
			r.pred = 16'sd32767;
		end else begin
			r.pred = acc[15:0];
		end
		ix = $signed({1'b0, si}) + IDX_ADJ[nib[2:0]];
		if (ix < 8'sd0) begin
			r.idx = 7'd0;
		end else if (ix > $signed({1'b0, IDX_MAX})) begin
			r.idx = IDX_MAX;
		end else begin
			r.idx = ix[6:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/apwd_parse.sv =====
`default_nettype none

module apwd_parse #(
	parameter int COUNT_BITS = apwd_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,
	output apwd_pkg::result_t res [apwd_pkg::MAX_RES],
	output apwd_pkg::res_load_t ld
);

	localparam logic [COUNT_BITS-1:0] POS_MAX = '1;
	localparam logic [COUNT_BITS-1:0] HDR = COUNT_BITS'(apwd_pkg::HDR_BYTES);

	logic [COUNT_BITS-1:0] pos_q, pos_n, d;
	logic [7:0] fmt_q, fmt_n, lflag_q, lflag_n, held_q, held_n;
	logic [15:0] rate_q, rate_n, loopw_q, loopw_n;
	logic [32:0] dataw_q, dataw_n;
	apwd_pkg::adpcm_st_t ad_q, ad_n, ad_mid;
	logic err_q, err_n;
	logic sat, hdr, active;
	logic [1:0] scnt;
	logic signed [15:0] s0, s1;
	apwd_pkg::result_t fin_r, samp0, samp1;
	logic [18:0] lstart;

	always_comb begin
		pos_n = pos_q;
		fmt_n = fmt_q;
		lflag_n = lflag_q;
		held_n = held_q;
		rate_n = rate_q;
		loopw_n = loopw_q;
		dataw_n = dataw_q;
		ad_n = ad_q;
		err_n = err_q;
		scnt = 2'd0;
		s0 = '0;
		s1 = '0;
		ad_mid = ad_q;

		sat = (pos_q == POS_MAX);
		hdr = !sat && (pos_q < HDR);
		d = pos_q - HDR;
		active = !sat && !hdr && !err_q &&
			({{(36 - COUNT_BITS){1'b0}}, d} < {1'b0, dataw_q, 2'b00});

		if (!sat) begin
			pos_n = pos_q + 1'b1;
		end

		if (hdr) begin
			case (pos_q[3:0])
				4'd0: begin
					fmt_n = data_byte;
					if (data_byte > apwd_pkg::FMT_ADPCM) begin
						err_n = 1'b1;
					end
				end
				4'd1: lflag_n = data_byte;
				4'd2: rate_n = {8'h00, data_byte};
				4'd3: rate_n[15:8] = data_byte;
				4'd6: loopw_n = {8'h00, data_byte};
				4'd7: loopw_n[15:8] = data_byte;
				4'd8: dataw_n = {25'd0, data_byte};
				4'd9: dataw_n[15:8] = data_byte;
				4'd10: dataw_n[23:16] = data_byte;
				4'd11: dataw_n = {1'b0, data_byte, dataw_q[23:0]} + {17'd0, loopw_q};
				default: ;
			endcase
		end

		if (active) begin
			case (fmt_q)
				apwd_pkg::FMT_PCM8: begin
					s0 = {data_byte, 8'h00};
					scnt = 2'd1;
				end
				apwd_pkg::FMT_PCM16: begin
					if (!d[0]) begin
						held_n = data_byte;
					end else begin
						s0 = {data_byte, held_q};
						scnt = 2'd1;
					end
				end
				apwd_pkg::FMT_ADPCM: begin
					if (d == '0) begin
						held_n = data_byte;
					end else if (d == COUNT_BITS'(1)) begin
						ad_n.pred = {data_byte, held_q};
					end else if (d == COUNT_BITS'(2)) begin
						ad_n.idx = (data_byte > {1'b0, apwd_pkg::IDX_MAX}) ?
							apwd_pkg::IDX_MAX : data_byte[6:0];
					end else if (d >= COUNT_BITS'(apwd_pkg::ADPCM_HDR_BYTES)) begin
						ad_mid = apwd_pkg::nibble_step(ad_q, data_byte[3:0]);
						ad_n = apwd_pkg::nibble_step(ad_mid, data_byte[7:4]);
						s0 = ad_mid.pred;
						s1 = ad_n.pred;
						scnt = 2'd2;
					end
				end
				default: ;
			endcase
		end

		case (fmt_n)
			apwd_pkg::FMT_PCM8: lstart = {1'b0, loopw_n, 2'b00};
			apwd_pkg::FMT_PCM16: lstart = {2'b00, loopw_n, 1'b0};
			default: lstart = (loopw_n == 16'd0) ? 19'd0 : {loopw_n - 16'd1, 3'b000};
		endcase

		fin_r = '0;
		if (pos_q < HDR - 1'b1) begin
			fin_r.kind = apwd_pkg::KIND_ERROR;
			fin_r.error_code = apwd_pkg::ERR_SHORT;
		end else if (fmt_n > apwd_pkg::FMT_ADPCM) begin
			fin_r.kind = apwd_pkg::KIND_ERROR;
			fin_r.error_code = apwd_pkg::ERR_FORMAT;
		end else if (fmt_n == apwd_pkg::FMT_ADPCM && (dataw_n == '0 ||
				pos_q < HDR + COUNT_BITS'(apwd_pkg::ADPCM_HDR_BYTES - 1))) begin
			fin_r.kind = apwd_pkg::KIND_ERROR;
			fin_r.error_code = apwd_pkg::ERR_ADPCM_HDR;
		end else begin
			fin_r.kind = apwd_pkg::KIND_INFO;
			fin_r.play_rate = rate_n;
			fin_r.loop_enabled = (lflag_n != 8'h00);
			fin_r.loop_point = lstart;
		end
		fin_r.last = 1'b1;

		samp0 = '0;
		samp0.kind = apwd_pkg::KIND_SAMPLE;
		samp0.sample = s0;
		samp0.last = !last_byte && (scnt == 2'd1);
		samp1 = '0;
		samp1.kind = apwd_pkg::KIND_SAMPLE;
		samp1.sample = s1;
		samp1.last = !last_byte;

		res[0] = (scnt != 2'd0) ? samp0 : fin_r;
		res[1] = (scnt == 2'd2) ? samp1 : fin_r;
		res[2] = fin_r;

		ld.load = en;
		ld.count = scnt + {1'b0, last_byte};

		if (last_byte) begin
			pos_n = '0;
			fmt_n = '0;
			lflag_n = '0;
			held_n = '0;
			rate_n = '0;
			loopw_n = '0;
			dataw_n = '0;
			ad_n = '0;
			err_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fmt_q <= '0;
			lflag_q <= '0;
			held_q <= '0;
			rate_q <= '0;
			loopw_q <= '0;
			dataw_q <= '0;
			ad_q <= '0;
			err_q <= 1'b0;
		end else if (en) begin
			pos_q <= pos_n;
			fmt_q <= fmt_n;
			lflag_q <= lflag_n;
			held_q <= held_n;
			rate_q <= rate_n;
			loopw_q <= loopw_n;
			dataw_q <= dataw_n;
			ad_q <= ad_n;
			err_q <= err_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/apwd_resq.sv =====
`default_nettype none

module apwd_resq (
	input wire logic clk,
	input wire logic arst_n,
	input wire apwd_pkg::res_load_t ld,
	input wire apwd_pkg::result_t res [apwd_pkg::MAX_RES],
	input wire logic stall,
	output logic valid,
	output apwd_pkg::result_t head,
	output logic can_load
);

	apwd_pkg::result_t slots_q [apwd_pkg::MAX_RES];
	logic [1:0] rem_q;
	logic [1:0] idx_q;
	logic pop;

	assign valid = (rem_q != 2'd0);
	assign pop = valid && !stall;
	assign can_load = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);
	assign head = slots_q[idx_q];

	always_ff @(posedge clk) begin
		if (ld.load && can_load) begin
			slots_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (ld.load && can_load) begin
			rem_q <= ld.count;
			idx_q <= 2'd0;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
			if (rem_q != 2'd1) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/adpcm_pcm_waveform_decoder_top.sv =====
// Channel   Handshake                   Payload
// item      item_valid / item_stall     data_byte, last_byte
// result    result_valid / result_stall kind, sample, play_rate, loop_enabled,
//                                       loop_point, error_code, last
//
// A request enters an input register and is decoded into up to three results.
// Results leave one per cycle, unless result_stall holds them, from a three-slot buffer.
// ADPCM data bytes give two samples, PCM samples one; the last byte adds a final result.
// The next request waits in the input register while the buffer still drains.
// Reset clears the header state, counters and valid flags; nothing else needs a pass.
`default_nettype none

module adpcm_pcm_waveform_decoder_top #(
	parameter int COUNT_BITS = apwd_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,
	output logic result_valid,
	input wire logic result_stall,
	output logic [1:0] kind,
	output logic signed [15:0] sample,
	output logic [15:0] play_rate,
	output logic loop_enabled,
	output logic [18:0] loop_point,
	output logic [1:0] error_code,
	output logic last
);

	logic in_valid_q;
	logic [7:0] byte_q;
	logic last_q;
	logic can_load;
	logic consume;
	apwd_pkg::result_t res [apwd_pkg::MAX_RES];
	apwd_pkg::res_load_t ld;
	apwd_pkg::result_t head;

	assign consume = in_valid_q && can_load;
	assign item_stall = in_valid_q && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
		end else if (item_valid && !item_stall) begin
			in_valid_q <= 1'b1;
		end else if (consume) begin
			in_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			byte_q <= data_byte;
			last_q <= last_byte;
		end
	end

	apwd_parse #(
		.COUNT_BITS(COUNT_BITS)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.en(consume),
		.data_byte(byte_q),
		.last_byte(last_q),
		.res(res),
		.ld(ld)
	);

	apwd_resq u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.ld(ld),
		.res(res),
		.stall(result_stall),
		.valid(result_valid),
		.head(head),
		.can_load(can_load)
	);

	assign kind = head.kind;
	assign sample = head.sample;
	assign play_rate = head.play_rate;
	assign loop_enabled = head.loop_enabled;
	assign loop_point = head.loop_point;
	assign error_code = head.error_code;
	assign last = head.last;

endmodule

`default_nettype wire
